@@ hw/rtl/wstq_pkg.sv @@
package wstq_pkg;

    // Request kind carried in the input tuser bit.
    localparam logic KIND_SCHED = 1'b1;

    localparam int OUT_HANDLE_W = 32;
    localparam int SOURCE_W     = 3;

    typedef struct packed {
        logic                    was_stolen;
        logic [SOURCE_W-1:0]     source;
        logic [OUT_HANDLE_W-1:0] out_handle;
        logic                    found;
        logic                    accepted;
    } t_result;

endpackage

@@ hw/rtl/work_stealing_task_queues_top.sv @@
// Channel     Dir  Signals                          Payload (low bit first)
// s_axis      in   tvalid tready tdata[39:0] tuser  tdata: worker, task_handle; tuser: kind
// m_axis      out  tvalid tready tdata[39:0]        accepted, found, out_handle, source,
//                                                   was_stolen
// cfg         in   valid ready data[3:0]            team_size
//
// A put passes through S_PUT and S_DONE. A schedule served from the worker's own
// queue passes through S_LOCAL, S_READ and S_DONE. A steal goes from S_LOCAL to S_MOD,
// which reduces the worker index modulo the team size, then S_PROBE, which probes up to
// the team size of queues, one per cycle through the shared bookkeeping port.
// Reset is synchronous and clears all queue pointers and counts at once.
// A result waits in the output register while the next request is taken.
module work_stealing_task_queues_top #(
    parameter int WORKERS     = 8,
    parameter int QUEUE_DEPTH = 128,
    parameter int HANDLE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // worker[2:0], task_handle[34:3]
    input  logic [0:0]  i_s_axis_tuser,  // kind[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // accepted[0], found[1], out_handle[33:2],
                                         // source[36:34], was_stolen[37]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);
    import wstq_pkg::*;

    logic [3:0] r_team;
    logic [3:0] n_team;
    t_result    res;

    // The stored team size is already clamped to one through WORKERS.
    always_comb begin
        priority if (i_cfg_data == 4'd0) begin
            n_team = 4'd1;
        end else if (32'(i_cfg_data) > WORKERS) begin
            n_team = 4'(WORKERS);
        end else begin
            n_team = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_team <= (WORKERS < 8) ? 4'(WORKERS) : 4'd8;
        end else if (i_cfg_valid) begin
            r_team <= n_team;
        end
    end

    assign o_cfg_ready = 1'b1;

    wstq_ctrl #(
        .WORKERS     (WORKERS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_team      (r_team),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_kind      (i_s_axis_tuser[0]),
        .i_worker    (i_s_axis_tdata[2:0]),
        .i_handle    (i_s_axis_tdata[34:3]),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res)
    );

    assign o_m_axis_tdata = {2'b00, res};

endmodule

@@ hw/rtl/wstq_ram.sv @@
module wstq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/wstq_ctrl.sv @@
module wstq_ctrl #(
    parameter int WORKERS     = 8,
    parameter int QUEUE_DEPTH = 128,
    parameter int HANDLE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [3:0]        i_team,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_kind,
    input  logic [2:0]        i_worker,
    input  logic [31:0]       i_handle,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output wstq_pkg::t_result o_res
);
    import wstq_pkg::*;

    localparam int WW     = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int VW     = (WW > 4) ? WW : 4;
    localparam int QW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int SW     = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
    localparam int RDEPTH = WORKERS * QUEUE_DEPTH;
    localparam int AW     = $clog2(RDEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_PUT, S_LOCAL, S_MOD, S_PROBE, S_READ, S_DONE
    } t_state;

    t_state        r_state;
    logic [2:0]    r_worker;
    logic [SW-1:0] r_handle;
    logic [VW-1:0] r_qsel;
    logic [3:0]    r_iter;
    logic [CW-1:0] r_count [WORKERS];
    logic [QW-1:0] r_front [WORKERS];
    logic [QW-1:0] r_back  [WORKERS];
    t_result       r_res;
    t_result       r_out;
    logic          r_out_valid;

    logic [WW-1:0] idx;
    logic          q_ok;
    logic [CW-1:0] cnt_sel;
    logic [QW-1:0] front_sel;
    logic [QW-1:0] back_sel;
    logic [QW-1:0] front_inc;
    logic [QW-1:0] back_inc;
    logic [QW-1:0] back_dec;
    logic [VW-1:0] team_v;
    logic [VW-1:0] worker_v;
    logic [VW-1:0] qsel_inc;
    logic [QW-1:0] ram_ptr;
    logic [AW-1:0] ram_addr;
    logic          ram_we;
    logic [SW-1:0] ram_rdata;

    // All per-queue bookkeeping goes through the one queue selected by r_qsel.
    assign idx       = r_qsel[WW-1:0];
    assign q_ok      = 32'(r_qsel) < WORKERS;
    assign cnt_sel   = q_ok ? r_count[idx] : '0;
    assign front_sel = q_ok ? r_front[idx] : '0;
    assign back_sel  = q_ok ? r_back[idx]  : '0;

    assign front_inc = (front_sel == QW'(QUEUE_DEPTH - 1)) ? '0 : front_sel + 1'b1;
    assign back_inc  = (back_sel == QW'(QUEUE_DEPTH - 1)) ? '0 : back_sel + 1'b1;
    assign back_dec  = (back_sel == '0) ? QW'(QUEUE_DEPTH - 1) : back_sel - 1'b1;

    assign team_v    = VW'(i_team);
    assign worker_v  = VW'(r_worker);
    assign qsel_inc  = r_qsel + 1'b1;

    always_comb begin
        ram_we = (r_state == S_PUT) && q_ok && (cnt_sel < CW'(QUEUE_DEPTH));
        unique case (r_state)
            S_PUT:   ram_ptr = back_sel;
            S_LOCAL: ram_ptr = back_dec;
            default: ram_ptr = front_sel;
        endcase
        ram_addr = AW'(idx) * AW'(QUEUE_DEPTH) + AW'(ram_ptr);
    end

    wstq_ram #(
        .WIDTH (SW),
        .DEPTH (RDEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_handle),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int w = 0; w < WORKERS; w++) begin
                r_count[w] <= '0;
                r_front[w] <= '0;
                r_back[w]  <= '0;
            end
        end else begin
            // S_DONE reloads the output register itself.
            if (r_out_valid && i_res_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_worker <= i_worker;
                        r_handle <= i_handle[SW-1:0];
                        r_qsel   <= VW'(i_worker);
                        r_res    <= '0;
                        r_state  <= (i_kind == KIND_SCHED) ? S_LOCAL : S_PUT;
                    end
                end
                S_PUT: begin
                    if (ram_we) begin
                        r_back[idx]    <= back_inc;
                        r_count[idx]   <= cnt_sel + 1'b1;
                        r_res.accepted <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_LOCAL: begin
                    if (q_ok && cnt_sel != '0) begin
                        r_back[idx]  <= back_dec;
                        r_count[idx] <= cnt_sel - 1'b1;
                        r_res.found  <= 1'b1;
                        r_res.source <= r_worker;
                        r_state      <= S_READ;
                    end else begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    // The probe starts at the worker index reduced modulo the team size.
                    if (r_qsel >= team_v) begin
                        r_qsel <= r_qsel - team_v;
                    end else begin
                        r_iter  <= '0;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (q_ok && cnt_sel != '0) begin
                        r_front[idx]     <= front_inc;
                        r_count[idx]     <= cnt_sel - 1'b1;
                        r_res.found      <= 1'b1;
                        r_res.source     <= r_qsel[2:0];
                        r_res.was_stolen <= (r_qsel != worker_v);
                        r_state          <= S_READ;
                    end else if (r_iter == i_team - 1'b1) begin
                        r_state <= S_DONE;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                        r_qsel <= (qsel_inc == team_v) ? '0 : qsel_inc;
                    end
                end
                S_READ: begin
                    r_res.out_handle <= 32'(ram_rdata);
                    r_state          <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_res_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

@@ dv/tb_work_stealing_task_queues_top.sv @@
module tb_work_stealing_task_queues_top;
    import wstq_pkg::*;

    localparam logic KIND_PUT     = 1'b0;
    localparam int   WORKERS      = 8;
    localparam int   QDEPTH       = 128;
    localparam int   SETTLE       = 40;
    localparam int   HOLD_CYCLES  = 150;
    localparam int   CYCLE_LIMIT  = 300000;
    localparam int   PRINT_LIMIT  = 50;

    typedef struct {
        logic        kind;
        logic [2:0]  worker;
        logic [31:0] task_handle;
    } t_task_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;  // worker[2:0], task_handle[34:3]
    logic [0:0]  i_s_axis_tuser = '0;  // kind[0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;       // accepted[0], found[1], out_handle[33:2],
                                       // source[36:34], was_stolen[37]
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data = '0;

    work_stealing_task_queues_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // Shadow copy of the per-worker rings and the team register.
    logic [31:0] deque_ring [WORKERS][QDEPTH];
    int          deque_head [WORKERS];
    int          deque_tail [WORKERS];
    int          deque_fill [WORKERS];
    logic [3:0]  team_reg = 4'd8;

    t_task_req   send_queue[$];
    t_result     expected_results[$];
    t_task_req   drv_req;
    int          send_gap = 0;
    int          rcv_gap = 0;
    int          taken_count = 0;
    int          hold_left = 0;
    int          hold_mark = -1;
    int          cycle_count = 0;
    int          mismatch_count = 0;
    logic        full_rate = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        return full_rate ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic logic [31:0] pick_handle();
        case ($urandom_range(0, 15))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_result serve_request(t_task_req r);
        t_result res;
        int      team;
        int      victim;
        int      w;
        res = '0;
        w = int'(r.worker);
        if (r.kind == KIND_PUT) begin
            if (deque_fill[w] < QDEPTH) begin
                deque_ring[w][deque_tail[w]] = r.task_handle;
                deque_tail[w] = (deque_tail[w] + 1) % QDEPTH;
                deque_fill[w]++;
                res.accepted = 1'b1;
            end
        end else if (deque_fill[w] != 0) begin
            // Own queue is popped from the back.
            deque_tail[w] = (deque_tail[w] + QDEPTH - 1) % QDEPTH;
            res.found = 1'b1;
            res.out_handle = deque_ring[w][deque_tail[w]];
            res.source = r.worker;
            deque_fill[w]--;
        end else begin
            // A team size of zero behaves as one, anything above the worker count as all.
            team = (team_reg == 0) ? 1 : ((team_reg > WORKERS) ? WORKERS : int'(team_reg));
            for (int i = 0; i < team; i++) begin
                victim = (w + i) % team;
                if (!res.found && deque_fill[victim] != 0) begin
                    res.found = 1'b1;
                    res.out_handle = deque_ring[victim][deque_head[victim]];
                    res.source = victim[2:0];
                    res.was_stolen = (victim != w);
                    deque_head[victim] = (deque_head[victim] + 1) % QDEPTH;
                    deque_fill[victim]--;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0d] %s: got %0h, expected %0h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(logic [39:0] data);
        t_result got;
        t_result want;
        got = t_result'(data[37:0]);
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing outstanding", data, 0);
        end else begin
            want = expected_results[0];
            expected_results.delete(0);
            if (got.accepted !== want.accepted)
                report_mismatch("accepted", got.accepted, want.accepted);
            if (got.found !== want.found)
                report_mismatch("found", got.found, want.found);
            if (got.out_handle !== want.out_handle)
                report_mismatch("out_handle", got.out_handle, want.out_handle);
            if (got.source !== want.source)
                report_mismatch("source", got.source, want.source);
            if (got.was_stolen !== want.was_stolen)
                report_mismatch("was_stolen", got.was_stolen, want.was_stolen);
        end
    endtask

    task automatic queue_req(logic kind, logic [2:0] worker, logic [31:0] task_handle);
        t_task_req r;
        r.kind = kind;
        r.worker = worker;
        r.task_handle = task_handle;
        send_queue.insert(send_queue.size(), r);
    endtask

    // Sampled at the falling edge so that the driver's updates have all landed.
    task automatic wait_drained();
        while (send_queue.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_team(logic [3:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        team_reg = value;
    endtask

    // Input driver: one request at a time, with a random gap after each transfer except in full-rate phases.
    always @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            expected_results.insert(expected_results.size(), serve_request(drv_req));
            taken_count <= taken_count + 1;
        end
        if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (send_queue.size() != 0) begin
                drv_req = send_queue[0];
                send_queue.delete(0);
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= {5'b0, drv_req.task_handle, drv_req.worker};
                i_s_axis_tuser <= drv_req.kind;
                send_gap <= draw_gap();
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            check_result(o_m_axis_tdata);
            rcv_gap = draw_gap();
        end else if (!i_m_axis_tready && rcv_gap > 0) begin
            rcv_gap = rcv_gap - 1;
        end
        i_m_axis_tready <= (hold_left == 0) && (rcv_gap == 0);
    end

    // Long receiver stalls so that the block backs up into its input.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if ((taken_count == 200 || taken_count == 650) && taken_count != hold_mark) begin
            hold_left <= HOLD_CYCLES;
            hold_mark <= taken_count;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        logic [3:0] team_plan [8];
        int         put_pct;
        logic [2:0] producer;
        logic       kind;
        team_plan = '{4'd0, 4'd15, 4'd1, 4'd5, 4'd8, 4'd2, 4'd9, 4'd7};
        for (int w = 0; w < WORKERS; w++) begin
            deque_head[w] = 0;
            deque_tail[w] = 0;
            deque_fill[w] = 0;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_team(4'd8);

        // Full team: empty schedule, local pops, steals in both directions.
        queue_req(KIND_SCHED, 3'd0, 32'h1234_5678);
        queue_req(KIND_PUT,   3'd0, 32'h0000_0000);
        queue_req(KIND_PUT,   3'd0, 32'hFFFF_FFFF);
        queue_req(KIND_PUT,   3'd7, 32'hA5A5_5A5A);
        queue_req(KIND_SCHED, 3'd0, 32'h0);
        queue_req(KIND_SCHED, 3'd0, 32'hFFFF_FFFF);
        queue_req(KIND_SCHED, 3'd0, 32'h0);
        queue_req(KIND_PUT,   3'd3, 32'h0000_0001);
        queue_req(KIND_PUT,   3'd3, 32'h8000_0000);
        queue_req(KIND_SCHED, 3'd5, 32'h0);
        queue_req(KIND_SCHED, 3'd3, 32'h0);
        queue_req(KIND_SCHED, 3'd1, 32'h0);
        wait_drained();

        // Small team: workers outside it keep their own queues but are not probed.
        write_team(4'd3);
        queue_req(KIND_PUT,   3'd6, 32'hDEAD_BEEF);
        queue_req(KIND_SCHED, 3'd6, 32'h0);
        queue_req(KIND_PUT,   3'd6, 32'h5555_AAAA);
        queue_req(KIND_SCHED, 3'd1, 32'h0);
        queue_req(KIND_SCHED, 3'd6, 32'h0);
        queue_req(KIND_PUT,   3'd2, 32'h7FFF_FFFF);
        queue_req(KIND_SCHED, 3'd7, 32'h0);
        queue_req(KIND_SCHED, 3'd4, 32'h0);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            write_team(team_plan[p]);
            full_rate <= p[0];
            put_pct = 35 + $urandom_range(0, 40);
            producer = 3'($urandom_range(0, 7));
            // One phase overruns a queue so that puts get refused.
            if (team_plan[p] == 4'd15) begin
                for (int n = 0; n < 135; n++)
                    queue_req(KIND_PUT, producer, pick_handle());
            end
            for (int n = 0; n < 90; n++) begin
                kind = ($urandom_range(0, 99) < put_pct) ? KIND_PUT : KIND_SCHED;
                if (kind == KIND_PUT && $urandom_range(0, 1) == 1)
                    queue_req(kind, producer, pick_handle());
                else
                    queue_req(kind, 3'($urandom_range(0, 7)), pick_handle());
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
